/* rtl/lpc_pkg.sv */
// ----------------------------------------------------------------------------
// lpc_pkg
// Shared codes and types for the lazy PMP region cache.
// ----------------------------------------------------------------------------
package lpc_pkg;

    typedef logic [1:0] t_mode;

    localparam t_mode MODE_INIT  = 2'd0;
    localparam t_mode MODE_ADD   = 2'd1;
    localparam t_mode MODE_SPLIT = 2'd2;
    localparam t_mode MODE_HIT   = 2'd3;

    localparam logic [2:0] ST_DONE  = 3'd0;
    localparam logic [2:0] ST_ADDED = 3'd1;
    localparam logic [2:0] ST_HIT   = 3'd2;
    localparam logic [2:0] ST_MISS  = 3'd3;
    localparam logic [2:0] ST_FULL  = 3'd4;

    localparam logic [7:0] PCFG_OFF      = 8'h00;
    localparam logic [7:0] PCFG_TOR_BASE = 8'h07;
    localparam logic [7:0] PCFG_TOR      = 8'h0F;
    localparam logic [7:0] PCFG_NAPOT    = 8'h1F;

    localparam logic CFG_IDX_BASE   = 1'b0;
    localparam logic CFG_IDX_LENGTH = 1'b1;

endpackage

/* rtl/lazy_pmp_region_cache.sv */
// ----------------------------------------------------------------------------
// lazy_pmp_region_cache
// Ordered host region table with merge, split and PMP programming on a hit.
// ----------------------------------------------------------------------------
// One item at a time. Each list position visited takes the order read, slot
// read and compare steps; a free slot search walks the slots from slot 0 up to
// the first free one or the last slot; removal and move-to-front take a read
// and a write step per shifted position. A hit then gives PMP_ENTRIES results:
// each listed region takes its visit before its one or two results, and the
// trailing off entries come one per cycle while the output is taken.
// Reset clears the slot valid bits and the region count at once; no sweep.
// ----------------------------------------------------------------------------
module lazy_pmp_region_cache
    import lpc_pkg::*;
#(
    parameter int REGION_SLOTS = 128,
    parameter int PMP_ENTRIES  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [63:0] i_address,
    input  logic [63:0] i_length,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [5:0]  o_pmp_index,
    output logic [53:0] o_pmp_address,
    output logic [7:0]  o_pmp_config,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    localparam int SW = $clog2(REGION_SLOTS);
    localparam int CW = $clog2(REGION_SLOTS + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_AST, S_F0, S_F1, S_F2, S_FREE, S_ADONE, S_RM, S_RM_W,
        S_SP0, S_SP1, S_SP2, S_MF, S_MF_W, S_HNAP, S_HT1, S_HT2, S_HOFF, S_RES
    } t_state;

    typedef enum logic [1:0] {C_FIND, C_SCAN, C_EMIT} t_ctx;

    t_state r_state;
    t_ctx   r_ctx;
    t_mode  r_mode;
    logic [63:0] r_sbase, r_slen;
    logic [63:0] r_addr, r_len;
    logic [63:0] r_apa, r_asz, r_aend;
    logic [63:0] r_b, r_l, r_off, r_rem;
    logic [2:0]  r_ares, r_res;
    logic        r_step;
    logic [CW-1:0] r_count, r_p, r_q;
    logic [SW-1:0] r_slot, r_fs;
    logic [5:0]    r_idx;
    logic [REGION_SLOTS-1:0] r_valid;

    logic        r_ovalid;
    logic [2:0]  r_ostat;
    logic [5:0]  r_oidx;
    logic [53:0] r_oaddr;
    logic [7:0]  r_ocfg;
    logic        r_olast;

    logic          ord_we, reg_we;
    logic [SW-1:0] ord_waddr, ord_raddr, reg_waddr;
    logic [SW-1:0] ord_wdata, ord_rdata;
    logic [127:0]  reg_wdata, reg_rdata;
    logic [63:0]   rb, rl, bl_sum, lm1;
    logic [63:0]   napot_top, tor_end;
    logic [CW-1:0] q_inc, q_dec;
    logic          out_free, out_load, contains, is_napot;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    lpc_ram #(.WIDTH(SW), .DEPTH(REGION_SLOTS)) u_order (
        .i_clk(i_clk), .i_we(ord_we), .i_waddr(ord_waddr), .i_wdata(ord_wdata),
        .i_raddr(ord_raddr), .o_rdata(ord_rdata)
    );

    lpc_ram #(.WIDTH(128), .DEPTH(REGION_SLOTS)) u_region (
        .i_clk(i_clk), .i_we(reg_we), .i_waddr(reg_waddr), .i_wdata(reg_wdata),
        .i_raddr(ord_rdata), .o_rdata(reg_rdata)
    );

    assign rb        = reg_rdata[127:64];
    assign rl        = reg_rdata[63:0];
    assign bl_sum    = rb + rl;
    assign lm1       = rl - 64'd1;
    assign contains  = (rb <= r_addr) && ((r_addr - rb) < rl);
    assign is_napot  = (rl != 64'd0) && ((rl & lm1) == 64'd0) && ((rb & lm1) == 64'd0);
    assign napot_top = r_b | (r_l - 64'd1);
    assign tor_end   = r_b + r_l;
    assign q_inc     = r_q + CW'(1);
    assign q_dec     = r_q - CW'(1);
    assign out_free  = !r_ovalid || i_out_ready;
    assign out_load  = out_free && (r_state == S_HNAP || r_state == S_HT1
                       || r_state == S_HT2 || r_state == S_HOFF || r_state == S_RES);

    always_comb begin
        ord_we    = 1'b0;
        ord_waddr = r_q[SW-1:0];
        ord_wdata = ord_rdata;
        reg_we    = 1'b0;
        reg_waddr = r_slot;
        reg_wdata = {rb, sat_add(rl, r_asz)};
        ord_raddr = r_p[SW-1:0];
        case (r_state)
            S_RM:   ord_raddr = q_inc[SW-1:0];
            S_MF:   begin
                ord_raddr = q_dec[SW-1:0];
                if (r_q == '0) begin
                    ord_we    = 1'b1;
                    ord_waddr = '0;
                    ord_wdata = r_slot;
                end
            end
            S_RM_W, S_MF_W: ord_we = 1'b1;
            S_F2: begin
                if (r_ctx == C_SCAN) begin
                    if (r_aend == rb) begin
                        reg_we    = 1'b1;
                        reg_wdata = {r_apa, sat_add(rl, r_asz)};
                    end else if (bl_sum == r_apa) begin
                        reg_we = 1'b1;
                    end
                end
            end
            S_FREE: begin
                if (!r_valid[r_fs] && r_count < CW'(REGION_SLOTS)) begin
                    reg_we    = 1'b1;
                    reg_waddr = r_fs;
                    reg_wdata = {r_apa, r_asz};
                    ord_we    = 1'b1;
                    ord_waddr = r_count[SW-1:0];
                    ord_wdata = r_fs;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_valid  <= '0;
            r_ovalid <= 1'b0;
            r_sbase  <= '0;
            r_slen   <= '0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_IDX_BASE) r_sbase <= i_cfg_data;
                if (i_cfg_index == CFG_IDX_LENGTH) r_slen <= i_cfg_data;
            end
            if (out_load) r_ovalid <= 1'b1;
            else if (i_out_ready) r_ovalid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_mode <= i_mode;
                        r_addr <= i_address;
                        r_len  <= i_length;
                        r_step <= 1'b0;
                        r_p    <= '0;
                        r_idx  <= 6'(PMP_ENTRIES - 1);
                        case (i_mode)
                            MODE_INIT: begin
                                r_valid <= '0;
                                r_count <= '0;
                                r_apa   <= '0;
                                r_asz   <= r_sbase;
                                r_state <= S_AST;
                            end
                            MODE_ADD: begin
                                r_apa   <= i_address;
                                r_asz   <= i_length;
                                r_state <= S_AST;
                            end
                            default: begin
                                r_ctx   <= C_FIND;
                                r_state <= S_F0;
                            end
                        endcase
                    end
                end
                S_AST: begin
                    if (r_asz == '0) begin
                        r_ares  <= ST_DONE;
                        r_state <= S_ADONE;
                    end else begin
                        r_aend  <= r_apa + r_asz;
                        r_p     <= '0;
                        r_ctx   <= C_SCAN;
                        r_state <= S_F0;
                    end
                end
                S_F0: begin
                    if (r_p >= r_count) begin
                        case (r_ctx)
                            C_FIND: begin
                                r_res   <= ST_MISS;
                                r_state <= S_RES;
                            end
                            C_SCAN: begin
                                if (r_count >= CW'(REGION_SLOTS)) begin
                                    r_ares  <= ST_FULL;
                                    r_state <= S_ADONE;
                                end else begin
                                    r_fs    <= '0;
                                    r_state <= S_FREE;
                                end
                            end
                            default: r_state <= S_HOFF;
                        endcase
                    end else begin
                        r_state <= S_F1;
                    end
                end
                S_F1: begin
                    r_slot  <= ord_rdata;
                    r_state <= S_F2;
                end
                S_F2: begin
                    r_b <= rb;
                    r_l <= rl;
                    case (r_ctx)
                        C_FIND: begin
                            if (contains) begin
                                r_q <= r_p;
                                if (r_mode == MODE_SPLIT) begin
                                    r_valid[r_slot] <= 1'b0;
                                    r_state         <= S_RM;
                                end else begin
                                    r_state <= S_MF;
                                end
                            end else begin
                                r_p     <= r_p + CW'(1);
                                r_state <= S_F0;
                            end
                        end
                        C_SCAN: begin
                            if ((r_aend == rb) || (bl_sum == r_apa)
                                || (rb == r_apa && rl == r_asz)) begin
                                r_ares  <= ST_DONE;
                                r_state <= S_ADONE;
                            end else begin
                                r_p     <= r_p + CW'(1);
                                r_state <= S_F0;
                            end
                        end
                        default: begin
                            if (is_napot) r_state <= S_HNAP;
                            else if (r_idx == '0) r_state <= S_HOFF;
                            else r_state <= S_HT1;
                        end
                    endcase
                end
                S_FREE: begin
                    if (!r_valid[r_fs]) begin
                        r_valid[r_fs] <= 1'b1;
                        r_count       <= r_count + CW'(1);
                        r_ares        <= ST_ADDED;
                        r_state       <= S_ADONE;
                    end else if (r_fs == SW'(REGION_SLOTS - 1)) begin
                        r_ares  <= ST_FULL;
                        r_state <= S_ADONE;
                    end else begin
                        r_fs <= r_fs + SW'(1);
                    end
                end
                S_ADONE: begin
                    case (r_mode)
                        MODE_INIT: begin
                            if (!r_step) begin
                                r_apa   <= r_sbase + r_slen;
                                r_asz   <= ~(r_sbase + r_slen);
                                r_step  <= 1'b1;
                                r_state <= S_AST;
                            end else begin
                                r_res   <= ST_DONE;
                                r_state <= S_RES;
                            end
                        end
                        MODE_ADD: begin
                            r_res   <= r_ares;
                            r_state <= S_RES;
                        end
                        default: begin
                            if (r_ares == ST_FULL) r_res <= ST_FULL;
                            r_state <= r_step ? S_RES : S_SP2;
                        end
                    endcase
                end
                S_RM: begin
                    if (q_inc >= r_count) begin
                        r_count <= r_count - CW'(1);
                        r_state <= S_SP0;
                    end else begin
                        r_state <= S_RM_W;
                    end
                end
                S_RM_W: begin
                    r_q     <= q_inc;
                    r_state <= S_RM;
                end
                S_SP0: begin
                    r_off   <= r_addr - r_b;
                    r_state <= S_SP1;
                end
                S_SP1: begin
                    r_rem  <= r_l - r_off;
                    r_res  <= ST_DONE;
                    r_step <= 1'b0;
                    if (r_off != '0) begin
                        r_apa   <= r_b;
                        r_asz   <= r_off;
                        r_state <= S_AST;
                    end else begin
                        r_state <= S_SP2;
                    end
                end
                S_SP2: begin
                    if (r_len < r_rem) begin
                        r_apa   <= r_addr + r_len;
                        r_asz   <= r_rem - r_len;
                        r_step  <= 1'b1;
                        r_state <= S_AST;
                    end else begin
                        r_state <= S_RES;
                    end
                end
                S_MF: begin
                    if (r_q == '0) begin
                        r_p     <= '0;
                        r_ctx   <= C_EMIT;
                        r_state <= S_F0;
                    end else begin
                        r_state <= S_MF_W;
                    end
                end
                S_MF_W: begin
                    r_q     <= q_dec;
                    r_state <= S_MF;
                end
                S_HNAP, S_HT2, S_HOFF: begin
                    if (out_free) begin
                        r_ostat  <= ST_HIT;
                        r_oidx   <= r_idx;
                        r_olast  <= (r_idx == '0);
                        if (r_state == S_HNAP) begin
                            r_oaddr <= napot_top[55:2];
                            r_ocfg  <= PCFG_NAPOT;
                        end else if (r_state == S_HT2) begin
                            r_oaddr <= r_b[55:2];
                            r_ocfg  <= PCFG_TOR_BASE;
                        end else begin
                            r_oaddr <= '0;
                            r_ocfg  <= PCFG_OFF;
                        end
                        if (r_idx == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx <= r_idx - 6'd1;
                            if (r_state != S_HOFF) begin
                                r_p     <= r_p + CW'(1);
                                r_state <= S_F0;
                            end
                        end
                    end
                end
                S_HT1: begin
                    if (out_free) begin
                        r_ostat  <= ST_HIT;
                        r_oidx   <= r_idx;
                        r_oaddr  <= tor_end[55:2];
                        r_ocfg   <= PCFG_TOR;
                        r_olast  <= 1'b0;
                        r_idx    <= r_idx - 6'd1;
                        r_state  <= S_HT2;
                    end
                end
                S_RES: begin
                    if (out_free) begin
                        r_ostat  <= r_res;
                        r_oidx   <= '0;
                        r_oaddr  <= '0;
                        r_ocfg   <= PCFG_OFF;
                        r_olast  <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_ovalid;
    assign o_status      = r_ostat;
    assign o_pmp_index   = r_oidx;
    assign o_pmp_address = r_oaddr;
    assign o_pmp_config  = r_ocfg;
    assign o_last        = r_olast;

    // The list can never hold more entries than there are slots.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(REGION_SLOTS))
        else $error("region count above slot total");

    // An accepted item keeps the block busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken again straight after an item");

    // Results other than a hit programming are single and final.
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_HIT) |-> o_last)
        else $error("non-hit result without last");

    // Hit results only name implemented PMP entries.
    a_pmp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_HIT) |-> ({1'b0, o_pmp_index} < 7'(PMP_ENTRIES)))
        else $error("PMP index beyond entry count");

endmodule

/* rtl/lpc_ram.sv */
// ----------------------------------------------------------------------------
// lpc_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
